[src/alat_pkg.sv]
// Shared types, codes and helpers of the latching alarm table.
package alat_pkg;

  localparam int unsigned MASK_W = 16;
  localparam int unsigned SEV_W  = 3;
  localparam int unsigned SEVTAB_W = 48;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned OUT_TIME_W = 32;
  localparam int unsigned NUM_SEV = 5;

  // Register indexes (byte address bits [5:3]).
  localparam logic [2:0] REG_REGISTERED = 3'd0;
  localparam logic [2:0] REG_ENABLE     = 3'd1;
  localparam logic [2:0] REG_LATCHING   = 3'd2;
  localparam logic [2:0] REG_HISTORY    = 3'd3;
  localparam logic [2:0] REG_SEVERITY   = 3'd4;

  // Event operations.
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNREG  = 2'd1;
  localparam logic [1:0] ST_DENIED = 2'd2;

  // History event codes.
  localparam logic [2:0] HIST_NONE    = 3'd0;
  localparam logic [2:0] HIST_RAISED  = 3'd1;
  localparam logic [2:0] HIST_CLEARED = 3'd2;
  localparam logic [2:0] HIST_RESET   = 3'd3;
  localparam logic [2:0] HIST_DENIED  = 3'd4;

  localparam logic [2:0] SEV_SAFETY = 3'd4;

  typedef struct packed {
    logic [MASK_W-1:0]   registered;
    logic [MASK_W-1:0]   enable;
    logic [MASK_W-1:0]   latching;
    logic [MASK_W-1:0]   history;
    logic [SEVTAB_W-1:0] severity;
  } alat_cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } alat_cmd_t;

  // Codes above safety count as safety.
  function automatic logic [SEV_W-1:0] sev_sat(logic [SEV_W-1:0] s);
    return (s > SEV_SAFETY) ? SEV_SAFETY : s;
  endfunction

endpackage

[src/alat_regs.sv]
// Configuration register file with the APB-style port.
module alat_regs #(
  parameter int unsigned NUM_ALARMS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [alat_pkg::ADDR_W-1:0] paddr,
  input  logic [alat_pkg::DATA_W-1:0] pwdata,
  output logic [alat_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output alat_pkg::alat_cfg_t        cfg_o,
  output logic [NUM_ALARMS-1:0]      clr_mask_o
);
  import alat_pkg::*;

  alat_cfg_t         cfg_q;
  logic              wr;
  logic [2:0]        sel;
  logic [MASK_W-1:0] chg;

  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[5:3];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Slots whose registration flips lose their whole state.
  assign chg        = cfg_q.registered ^ pwdata[MASK_W-1:0];
  assign clr_mask_o = (wr && (sel == REG_REGISTERED)) ? chg[NUM_ALARMS-1:0]
                                                      : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      case (sel)
        REG_REGISTERED: cfg_q.registered <= pwdata[MASK_W-1:0];
        REG_ENABLE:     cfg_q.enable     <= pwdata[MASK_W-1:0];
        REG_LATCHING:   cfg_q.latching   <= pwdata[MASK_W-1:0];
        REG_HISTORY:    cfg_q.history    <= pwdata[MASK_W-1:0];
        REG_SEVERITY:   cfg_q.severity   <= pwdata[SEVTAB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_REGISTERED: prdata = DATA_W'(cfg_q.registered);
      REG_ENABLE:     prdata = DATA_W'(cfg_q.enable);
      REG_LATCHING:   prdata = DATA_W'(cfg_q.latching);
      REG_HISTORY:    prdata = DATA_W'(cfg_q.history);
      REG_SEVERITY:   prdata = DATA_W'(cfg_q.severity);
      default:        prdata = '0;
    endcase
  end

endmodule

[src/alat_ctrl.sv]
// Controller state machine: accepts an event and sequences its execution.
module alat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  output alat_pkg::alat_cmd_t cmd_o
);
  import alat_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign cmd_o.capture = start_i && !busy_q;
  assign cmd_o.exec    = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

[src/alat_dp.sv]
// Datapath: alarm state, per-event update and aggregate reduction.
module alat_dp #(
  parameter int unsigned NUM_ALARMS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  alat_pkg::alat_cmd_t       cmd_i,
  input  alat_pkg::alat_cfg_t       cfg_i,
  input  logic [NUM_ALARMS-1:0]     clr_mask_i,
  input  logic                      op_i,
  input  logic [3:0]                alarm_index_i,
  input  logic                      condition_i,
  input  logic [31:0]               now_ms_i,
  output logic [1:0]                status_o,
  output logic                      alarm_active_o,
  output logic                      alarm_latched_o,
  output logic                      clear_ok_o,
  output logic [31:0]               rise_count_o,
  output logic [31:0]               activation_time_o,
  output logic [2:0]                history_event_o,
  output logic                      latch_event_o,
  output logic [4:0]                live_count_o,
  output logic [4:0]                severity_flags_o,
  output logic [2:0]                top_severity_o,
  output logic [3:0]                highest_index_o
);
  import alat_pkg::*;

  localparam int unsigned IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

  // Captured event
  logic                 op_q;
  logic [3:0]           idx_q;
  logic                 cond_q;
  logic [TIME_BITS-1:0] now_q;

  // Alarm state
  logic [NUM_ALARMS-1:0] cflag_q, act_q, lat_q;
  logic [CNT_W-1:0]      cnt_q [NUM_ALARMS];
  logic [TIME_BITS-1:0]  tim_q [NUM_ALARMS];

  // Result registers
  logic [1:0]  status_q;
  logic        a_q, l_q, ra_q, lev_q;
  logic [31:0] cnt_out_q, tim_out_q;
  logic [2:0]  hist_q;
  logic [4:0]  count_q, flags_q;
  logic [2:0]  best_q;
  logic [3:0]  bidx_q;

  // Update logic
  logic [IDX_W-1:0]      slot;
  logic                  slot_ok;
  logic                  en, lat, hen, pc, pa, pl, na, nl;
  logic [NUM_ALARMS-1:0] cflag_d, act_d, lat_d;
  logic [CNT_W-1:0]      cnt_new;
  logic [TIME_BITS-1:0]  tim_new;
  logic [1:0]            status_d;
  logic [2:0]            hist_d;
  logic                  lev_d;

  // Aggregates
  logic [NUM_ALARMS-1:0] live, match;
  logic [SEV_W-1:0]      sev [NUM_ALARMS];
  logic [4:0]            count_d, flags_d;
  logic [2:0]            best_d, best_sev;
  logic [3:0]            bidx_d;

  assign slot    = idx_q[IDX_W-1:0];
  assign slot_ok = ({1'b0, idx_q} < 5'(NUM_ALARMS)) && cfg_i.registered[idx_q];
  assign en      = cfg_i.enable[idx_q];
  assign lat     = cfg_i.latching[idx_q];
  assign hen     = cfg_i.history[idx_q];
  assign pc      = cflag_q[slot];
  assign pa      = act_q[slot];
  assign pl      = lat_q[slot];

  always_comb begin
    cflag_d  = cflag_q;
    act_d    = act_q;
    lat_d    = lat_q;
    cnt_new  = cnt_q[slot];
    tim_new  = tim_q[slot];
    status_d = ST_OK;
    hist_d   = HIST_NONE;
    lev_d    = 1'b0;
    na       = 1'b0;
    nl       = 1'b0;
    if (!slot_ok) begin
      status_d = ST_UNREG;
    end else if (op_q == OP_SET) begin
      if (!en) begin
        na = 1'b0;
        nl = 1'b0;
      end else if (!lat) begin
        na = cond_q;
        nl = 1'b0;
      end else if (cond_q) begin
        na = 1'b1;
        nl = 1'b1;
      end else begin
        nl = pl;
        na = pl && pa;
      end
      if (!pa && na) begin
        if (cnt_new != '1) begin
          cnt_new = cnt_new + 1'b1;
        end
        tim_new = now_q;
      end else if (pa && !na) begin
        tim_new = '0;
      end
      cflag_d[slot] = cond_q;
      act_d[slot]   = na;
      lat_d[slot]   = nl;
      if (hen) begin
        if (pc != cond_q) begin
          hist_d = cond_q ? HIST_RAISED : HIST_CLEARED;
        end
        lev_d = !pl && nl;
      end
    end else if (lat) begin
      if (pc) begin
        status_d = ST_DENIED;
        if (hen) begin
          hist_d = HIST_DENIED;
        end
      end else if (pa || pl || (tim_new != '0)) begin
        act_d[slot] = 1'b0;
        lat_d[slot] = 1'b0;
        tim_new     = '0;
        if (hen) begin
          hist_d = HIST_RESET;
        end
      end
    end
  end

  // Severity flags first, then the lowest slot at the top level.
  always_comb begin
    count_d = '0;
    flags_d = '0;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      live[i] = act_d[i] && cfg_i.registered[i];
      sev[i]  = sev_sat(cfg_i.severity[SEV_W*i +: SEV_W]);
      count_d = count_d + 5'(live[i]);
      if (live[i]) begin
        flags_d = flags_d | (5'd1 << sev[i]);
      end
    end
    best_d = '0;
    for (int s = 0; s < NUM_SEV; s++) begin
      if (flags_d[s]) begin
        best_d = 3'(s + 1);
      end
    end
    best_sev = best_d - 3'd1;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      match[i] = live[i] && (sev[i] == best_sev);
    end
    bidx_d = '0;
    for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
      if (match[i]) begin
        bidx_d = 4'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      idx_q  <= alarm_index_i;
      cond_q <= condition_i;
      now_q  <= TIME_BITS'(now_ms_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cflag_q <= '0;
      act_q   <= '0;
      lat_q   <= '0;
      for (int i = 0; i < NUM_ALARMS; i++) begin
        cnt_q[i] <= '0;
        tim_q[i] <= '0;
      end
    end else begin
      if (cmd_i.exec && slot_ok) begin
        cflag_q     <= cflag_d;
        act_q       <= act_d;
        lat_q       <= lat_d;
        cnt_q[slot] <= cnt_new;
        tim_q[slot] <= tim_new;
      end
      for (int i = 0; i < NUM_ALARMS; i++) begin
        if (clr_mask_i[i]) begin
          cflag_q[i] <= 1'b0;
          act_q[i]   <= 1'b0;
          lat_q[i]   <= 1'b0;
          cnt_q[i]   <= '0;
          tim_q[i]   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      a_q       <= slot_ok && act_d[slot];
      l_q       <= slot_ok && lat_d[slot];
      ra_q      <= slot_ok && lat && act_d[slot] && lat_d[slot] && !cflag_d[slot];
      cnt_out_q <= slot_ok ? 32'(cnt_new) : '0;
      tim_out_q <= slot_ok ? OUT_TIME_W'(tim_new) : '0;
      hist_q    <= hist_d;
      lev_q     <= lev_d;
      count_q   <= count_d;
      flags_q   <= flags_d;
      best_q    <= best_d;
      bidx_q    <= bidx_d;
    end
  end

  assign status_o           = status_q;
  assign alarm_active_o     = a_q;
  assign alarm_latched_o    = l_q;
  assign clear_ok_o         = ra_q;
  assign rise_count_o       = cnt_out_q;
  assign activation_time_o  = tim_out_q;
  assign history_event_o    = hist_q;
  assign latch_event_o      = lev_q;
  assign live_count_o       = count_q;
  assign severity_flags_o   = flags_q;
  assign top_severity_o     = best_q;
  assign highest_index_o    = bidx_q;

endmodule

[src/latching_alarm_table_top.sv]
// Top level of the latching alarm table: registers, controller and datapath.
//
// Usage:
//   Event channel: drive op_i, alarm_index_i, condition_i and now_ms_i and
//   raise start_i; the transaction is taken at the rising edge where start_i
//   is high and busy_o is low. busy_o then stays high for one cycle while the
//   datapath reads the addressed slot, updates it and reduces the flags of all
//   slots into the count, severity flags, highest severity and its index.
//   Result channel: done_o pulses for exactly one cycle as the controller
//   leaves its execute state, with all result ports valid in that cycle.
//   The receiver cannot stall; capture the result while done_o is high.
//   Events do not overlap: busy_o holds off new starts during the single
//   execute state; a new start is taken in the cycle done_o is shown.
//   Configuration: APB-style port, 64-bit data, register i at byte address
//   8*i; writes complete in the access cycle (pready is tied high). Write
//   only while idle. Changing a registered bit clears that slot's state.
//   Reset: rst_ni clears the configuration registers, alarm flags, counts and
//   time stamps; no event is in flight and done_o is low afterwards.
module latching_alarm_table_top #(
  parameter int unsigned NUM_ALARMS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Event transaction
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        op_i,
  input  logic [3:0]                  alarm_index_i,
  input  logic                        condition_i,
  input  logic [31:0]                 now_ms_i,
  // Result transaction
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic                        alarm_active_o,
  output logic                        alarm_latched_o,
  output logic                        clear_ok_o,
  output logic [31:0]                 rise_count_o,
  output logic [31:0]                 activation_time_o,
  output logic [2:0]                  history_event_o,
  output logic                        latch_event_o,
  output logic [4:0]                  live_count_o,
  output logic [4:0]                  severity_flags_o,
  output logic [2:0]                  top_severity_o,
  output logic [3:0]                  highest_index_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alat_pkg::ADDR_W-1:0] paddr,
  input  logic [alat_pkg::DATA_W-1:0] pwdata,
  output logic [alat_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import alat_pkg::*;

  alat_cfg_t             cfg;
  alat_cmd_t             cmd;
  logic [NUM_ALARMS-1:0] clr_mask;

  // Hold the configuration and flag slots whose registration flips.
  alat_regs #(
    .NUM_ALARMS(NUM_ALARMS)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .clr_mask_o(clr_mask)
  );

  // Sequence each event: capture, execute, strobe the result.
  alat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Update the addressed slot and reduce over all slots.
  alat_dp #(
    .NUM_ALARMS(NUM_ALARMS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .clr_mask_i        (clr_mask),
    .op_i              (op_i),
    .alarm_index_i     (alarm_index_i),
    .condition_i       (condition_i),
    .now_ms_i          (now_ms_i),
    .status_o          (status_o),
    .alarm_active_o    (alarm_active_o),
    .alarm_latched_o   (alarm_latched_o),
    .clear_ok_o        (clear_ok_o),
    .rise_count_o      (rise_count_o),
    .activation_time_o (activation_time_o),
    .history_event_o   (history_event_o),
    .latch_event_o     (latch_event_o),
    .live_count_o      (live_count_o),
    .severity_flags_o  (severity_flags_o),
    .top_severity_o    (top_severity_o),
    .highest_index_o   (highest_index_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted event is in execution in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted event did not enter execution");

  // Execution always ends in a result strobe, with busy_o low again.
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o && !busy_o)
    else $error("execution did not produce a result strobe");

  // The active count never exceeds the number of slots.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> live_count_o <= 5'(NUM_ALARMS))
    else $error("active count out of range");

  // No active alarm exactly when no highest severity is reported.
  a_best_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((top_severity_o == 3'd0) == (live_count_o == 5'd0)))
    else $error("highest severity disagrees with active count");

  // An unregistered slot reports no per-alarm state.
  a_unreg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_UNREG) |->
      !alarm_active_o && !alarm_latched_o && (rise_count_o == 32'd0)
      && (history_event_o == HIST_NONE))
    else $error("unregistered slot reported state");
`endif

endmodule

[test/alat_checker.sv]
// Checker for the latching alarm table: event predictor and result scoreboard.
module alat_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          op_i,
  input  logic [3:0]                    alarm_index_i,
  input  logic                          condition_i,
  input  logic [31:0]                   now_ms_i,
  input  logic                          done_i,
  input  logic [1:0]                    status_i,
  input  logic                          alarm_active_i,
  input  logic                          alarm_latched_i,
  input  logic                          clear_ok_i,
  input  logic [31:0]                   rise_count_i,
  input  logic [31:0]                   activation_time_i,
  input  logic [2:0]                    history_event_i,
  input  logic                          latch_event_i,
  input  logic [4:0]                    live_count_i,
  input  logic [4:0]                    severity_flags_i,
  input  logic [2:0]                    top_severity_i,
  input  logic [3:0]                    highest_index_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [alat_pkg::ADDR_W-1:0]   paddr,
  input  logic [alat_pkg::DATA_W-1:0]   pwdata,
  input  logic                          pready,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import alat_pkg::*;

  localparam int unsigned SLOTS = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic        active;
    logic        latched;
    logic        reset_ok;
    logic [31:0] act_count;
    logic [31:0] act_time;
    logic [2:0]  hist;
    logic        latch_ev;
    logic [4:0]  live_count;
    logic [4:0]  sev_flags;
    logic [2:0]  top_sev;
    logic [3:0]  top_idx;
  } alarm_status_t;

  alat_cfg_t       cfg_q;
  logic [SLOTS-1:0] cond_q, active_q, latched_q;
  logic [31:0]     act_count_q [SLOTS];
  logic [31:0]     act_time_q  [SLOTS];
  alarm_status_t   expected_status_q [$];

  function automatic void clear_slot(input int unsigned i);
    cond_q[i]      = 1'b0;
    active_q[i]    = 1'b0;
    latched_q[i]   = 1'b0;
    act_count_q[i] = '0;
    act_time_q[i]  = '0;
  endfunction

  // Apply one event to the shadow table and return the status it reports.
  function automatic alarm_status_t annunciate(input logic op, input logic [3:0] idx,
                                               input logic cond, input logic [31:0] now);
    alarm_status_t r;
    logic en, lat, hen, pc, pa, pl, na, nl;
    logic [2:0] sev;
    r = '0;
    if (!cfg_q.registered[idx]) begin
      r.status = ST_UNREG;
    end else begin
      en  = cfg_q.enable[idx];
      lat = cfg_q.latching[idx];
      hen = cfg_q.history[idx];
      pc  = cond_q[idx];
      pa  = active_q[idx];
      pl  = latched_q[idx];
      if (op == OP_SET) begin
        if (!en) begin
          na = 1'b0; nl = 1'b0;
        end else if (!lat) begin
          na = cond; nl = 1'b0;
        end else if (cond) begin
          na = 1'b1; nl = 1'b1;
        end else begin
          nl = pl; na = pl ? pa : 1'b0;
        end
        if (!pa && na) begin
          if (act_count_q[idx] != 32'hFFFF_FFFF) act_count_q[idx] = act_count_q[idx] + 32'd1;
          act_time_q[idx] = now;
        end else if (pa && !na) begin
          act_time_q[idx] = '0;
        end
        cond_q[idx]    = cond;
        active_q[idx]  = na;
        latched_q[idx] = nl;
        if (hen) begin
          if (pc != cond) r.hist = cond ? HIST_RAISED : HIST_CLEARED;
          if (!pl && nl) r.latch_ev = 1'b1;
        end
      end else if (lat) begin
        if (pc) begin
          r.status = ST_DENIED;
          if (hen) r.hist = HIST_DENIED;
        end else if (pa || pl || act_time_q[idx] != '0) begin
          active_q[idx]   = 1'b0;
          latched_q[idx]  = 1'b0;
          act_time_q[idx] = '0;
          if (hen) r.hist = HIST_RESET;
        end
      end
      r.active    = active_q[idx];
      r.latched   = latched_q[idx];
      r.reset_ok  = lat && active_q[idx] && latched_q[idx] && !cond_q[idx];
      r.act_count = act_count_q[idx];
      r.act_time  = act_time_q[idx];
    end
    // Reduce over every registered active slot; ties keep the lowest slot.
    for (int i = 0; i < SLOTS; i++) begin
      if (cfg_q.registered[i] && active_q[i]) begin
        sev = cfg_q.severity[3*i +: 3];
        if (sev > SEV_SAFETY) sev = SEV_SAFETY;
        r.live_count = r.live_count + 5'd1;
        r.sev_flags[sev] = 1'b1;
        if (3'(sev + 3'd1) > r.top_sev) begin
          r.top_sev = 3'(sev + 3'd1);
          r.top_idx = 4'(i);
        end
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alarm_status_t want;
    logic [SLOTS-1:0] changed;
    if (!rst_ni) begin
      cfg_q     = '0;
      cond_q    = '0;
      active_q  = '0;
      latched_q = '0;
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
      expected_status_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (expected_status_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count_o++;
        end else begin
          want = expected_status_q.pop_front();
          compare_field("status",           want.status,       status_i);
          compare_field("alarm_active",     want.active,       alarm_active_i);
          compare_field("alarm_latched",    want.latched,      alarm_latched_i);
          compare_field("clear_ok",         want.reset_ok,     clear_ok_i);
          compare_field("rise_count",       want.act_count,    rise_count_i);
          compare_field("activation_time",  want.act_time,     activation_time_i);
          compare_field("history_event",    want.hist,         history_event_i);
          compare_field("latch_event",      want.latch_ev,     latch_event_i);
          compare_field("live_count",       want.live_count,   live_count_i);
          compare_field("severity_flags",   want.sev_flags,    severity_flags_i);
          compare_field("top_severity",     want.top_sev,      top_severity_i);
          compare_field("highest_index",    want.top_idx,      highest_index_i);
        end
      end
      if (start_i && !busy_i)
        expected_status_q.insert(expected_status_q.size(),
                                 annunciate(op_i, alarm_index_i, condition_i, now_ms_i));
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_REGISTERED: begin
            changed = cfg_q.registered ^ pwdata[15:0];
            for (int i = 0; i < SLOTS; i++)
              if (changed[i]) clear_slot(i);
            cfg_q.registered = pwdata[15:0];
          end
          REG_ENABLE:   cfg_q.enable   = pwdata[15:0];
          REG_LATCHING: cfg_q.latching = pwdata[15:0];
          REG_HISTORY:  cfg_q.history  = pwdata[15:0];
          REG_SEVERITY: cfg_q.severity = pwdata[SEVTAB_W-1:0];
          default: ;
        endcase
      end
      pending_o = expected_status_q.size();
    end
  end

endmodule

[test/tb_top.sv]
// Testbench top for the latching alarm table: stimulus, configuration and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import alat_pkg::*;

  // Generous bound: ~1250 events plus the longest gaps and a few dozen
  // register writes stay far below this.
  localparam int unsigned CYCLE_LIMIT = 300_000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 150;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                op_i = OP_SET;
  logic [3:0]          alarm_index_i = '0;
  logic                condition_i = 1'b0;
  logic [31:0]         now_ms_i = '0;
  logic                done_o;
  logic [1:0]          status_o;
  logic                alarm_active_o;
  logic                alarm_latched_o;
  logic                clear_ok_o;
  logic [31:0]         rise_count_o;
  logic [31:0]         activation_time_o;
  logic [2:0]          history_event_o;
  logic                latch_event_o;
  logic [4:0]          live_count_o;
  logic [4:0]          severity_flags_o;
  logic [2:0]          top_severity_o;
  logic [3:0]          highest_index_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  always #2 clk_i = ~clk_i;

  latching_alarm_table_top DUT (.*);

  alat_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .op_i               (op_i),
    .alarm_index_i      (alarm_index_i),
    .condition_i        (condition_i),
    .now_ms_i           (now_ms_i),
    .done_i             (done_o),
    .status_i           (status_o),
    .alarm_active_i     (alarm_active_o),
    .alarm_latched_i    (alarm_latched_o),
    .clear_ok_i         (clear_ok_o),
    .rise_count_i       (rise_count_o),
    .activation_time_i  (activation_time_o),
    .history_event_i    (history_event_o),
    .latch_event_i      (latch_event_o),
    .live_count_i       (live_count_o),
    .severity_flags_i   (severity_flags_o),
    .top_severity_i     (top_severity_o),
    .highest_index_i    (highest_index_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Stop a hung run: a missing done or a stuck busy ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL latching_alarm_table_top");
      $finish;
    end
  end

  // Issue one event transaction. Called in the time step of the previous
  // acceptance, so start_i gets exactly one assignment per step: drop it for
  // a gap, or hold it high straight into the next transaction.
  task automatic post_alarm_event(input logic op, input logic [3:0] idx, input logic cond,
                                  input logic [31:0] now, input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i          <= op;
    alarm_index_i <= idx;
    condition_i   <= cond;
    now_ms_i      <= now;
    start_i       <= 1'b1;
    // Advance until an edge sees start high and busy low.
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start, then wait until every expected result has come back and let
  // the pipeline settle before touching the registers.
  task automatic drain_events();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, access cycle, then an idle cycle so that the
  // next write never reassigns psel in the same step.
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [47:0]       sev_tab;
    logic [DATA_W-1:0] noise;
    logic [15:0]       reg_m, en_m, lat_m, hist_m;
    logic [3:0]        hot [4];
    logic [3:0]        idx;
    logic [31:0]       now;
    logic              quiet;
    int unsigned       r, gap;

    // Hold reset, then release it once for the whole run.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing is registered out of reset: any event reports an unregistered slot.
    post_alarm_event(OP_SET, 4'd3, 1'b1, 32'h0000_1234, 0);
    drain_events();

    // Directed table: slot 15 unregistered, slot 14 disabled, slots 0-7
    // latching, history on 0-7 and 12-15, severity code i mod 8 per slot so
    // that codes five to seven appear.
    for (int i = 0; i < 16; i++) sev_tab[3*i +: 3] = 3'(i);
    write_reg(REG_REGISTERED, 64'h0000_0000_0000_7FFF);
    write_reg(REG_ENABLE,     64'h0000_0000_0000_BFFF);
    write_reg(REG_LATCHING,   64'h0000_0000_0000_00FF);
    write_reg(REG_HISTORY,    64'h0000_0000_0000_F0FF);
    write_reg(REG_SEVERITY,   {16'h0000, sev_tab});

    post_alarm_event(OP_SET,   4'd0,  1'b1, 32'hFFFF_FFFF, 0); // raise and latch
    post_alarm_event(OP_RESET, 4'd0,  1'b0, 32'h0000_0000, 0); // denied, condition held
    post_alarm_event(OP_SET,   4'd0,  1'b0, 32'h0000_0001, 1); // cleared, stays latched
    post_alarm_event(OP_RESET, 4'd0,  1'b1, 32'h0000_0002, 0); // reset, condition ignored
    post_alarm_event(OP_RESET, 4'd0,  1'b0, 32'h0000_0003, 2); // nothing to clear
    post_alarm_event(OP_SET,   4'd8,  1'b1, 32'h0000_0000, 0); // follows condition, stamp 0
    post_alarm_event(OP_RESET, 4'd8,  1'b0, 32'h0000_0004, 0); // reset of non-latching
    post_alarm_event(OP_SET,   4'd8,  1'b0, 32'h0000_0005, 0);
    post_alarm_event(OP_SET,   4'd14, 1'b1, 32'h0000_0006, 0); // disabled alarm
    post_alarm_event(OP_SET,   4'd15, 1'b1, 32'h0000_0007, 3); // unregistered slot
    post_alarm_event(OP_RESET, 4'd15, 1'b0, 32'h0000_0008, 0);
    post_alarm_event(OP_SET,   4'd7,  1'b1, 32'h0000_0009, 0); // code 7 counts as safety
    post_alarm_event(OP_SET,   4'd5,  1'b1, 32'h0000_000A, 0); // code 5 counts as safety
    post_alarm_event(OP_SET,   4'd4,  1'b1, 32'h0000_000B, 0); // lowest safety slot wins
    post_alarm_event(OP_SET,   4'd3,  1'b1, 32'h8000_0000, 0);
    post_alarm_event(OP_SET,   4'd3,  1'b1, 32'h7FFF_FFFF, 0); // no change, no event
    post_alarm_event(OP_SET,   4'd12, 1'b1, 32'h5555_AAAA, 1);
    post_alarm_event(OP_RESET, 4'd3,  1'b1, 32'hAAAA_5555, 0);
    drain_events();

    // Latching and enable changes apply at the alarm's next event.
    write_reg(REG_LATCHING, 64'h0000_0000_0000_0000);
    write_reg(REG_ENABLE,   64'h0000_0000_0000_BFEF);
    post_alarm_event(OP_SET,   4'd3, 1'b0, 32'h0000_0010, 0);
    post_alarm_event(OP_SET,   4'd4, 1'b1, 32'h0000_0011, 0);
    drain_events();

    // Registration change: removing and re-adding slots wipes their state.
    write_reg(REG_REGISTERED, 64'h0000_0000_0000_7FF0);
    post_alarm_event(OP_SET, 4'd2, 1'b1, 32'h0000_0012, 0);
    drain_events();
    write_reg(REG_REGISTERED, 64'h0000_0000_0000_FFFF);
    post_alarm_event(OP_SET, 4'd5, 1'b0, 32'h0000_0013, 0);
    post_alarm_event(OP_SET, 4'd0, 1'b1, 32'h0000_0014, 0);

    // Random phases: each reprograms the table while idle, then streams events
    // that mostly hammer a few hot slots so the latch/reset sequences build up.
    for (int p = 0; p < PHASES; p++) begin
      drain_events();
      noise = {$urandom(), $urandom()};
      if (p == 0) begin
        // Everything on, all severity codes at the top.
        reg_m = 16'hFFFF; en_m = 16'hFFFF; lat_m = 16'hFFFF; hist_m = 16'hFFFF;
        sev_tab = '1;
      end else if (p == 1) begin
        // Everything registered, nothing else.
        reg_m = 16'hFFFF; en_m = 16'h0000; lat_m = 16'h0000; hist_m = 16'h0000;
        sev_tab = '0;
      end else begin
        reg_m   = 16'($urandom() | $urandom());
        en_m    = 16'($urandom() | $urandom());
        lat_m   = 16'($urandom());
        hist_m  = 16'($urandom());
        sev_tab = {16'($urandom()), $urandom()};
      end
      // Keep registrations across some phases so state carries over.
      if (p < 2 || $urandom_range(0, 1) == 1)
        write_reg(REG_REGISTERED, {noise[63:16], reg_m});
      write_reg(REG_ENABLE,   {noise[47:0], en_m});
      write_reg(REG_LATCHING, {noise[31:0], noise[63:48], lat_m});
      write_reg(REG_HISTORY,  {noise[15:0], noise[63:32], hist_m});
      write_reg(REG_SEVERITY, {noise[63:48], sev_tab});

      for (int h = 0; h < 4; h++) hot[h] = 4'($urandom_range(0, 15));
      quiet = (p == 0 || p == 4);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        idx = ($urandom_range(0, 99) < 70) ? hot[$urandom_range(0, 3)]
                                           : 4'($urandom_range(0, 15));
        r = $urandom_range(0, 19);
        now = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
        // Mostly back-to-back or short gaps, with the odd long pause.
        r = $urandom_range(0, 99);
        if (quiet || r < 60) gap = 0;
        else if (r < 90)     gap = $urandom_range(1, 3);
        else                 gap = $urandom_range(8, 40);
        post_alarm_event(($urandom_range(0, 99) < 40) ? OP_RESET : OP_SET, idx,
                         1'($urandom_range(0, 1)), now, gap);
      end
    end
    drain_events();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS latching_alarm_table_top");
    end else begin
      $display("FAIL latching_alarm_table_top");
    end
    $finish;
  end

endmodule
